### design/base32_stream_codec_macros.svh
// Assertion macros shared by the base32 stream codec modules.
// The asserting module must have signals named clk and rst in scope.
`ifndef BASE32_STREAM_CODEC_MACROS_SVH
`define BASE32_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, off during reset.
`define B32C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define B32C_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/b32c_pkg.sv
// Types, constants and lookup functions for the base32 stream codec.
// No dependencies; every other design file but the macro header refers to it by scoped names.
package b32c_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       last;
  } out_t;

  // Results produced by one input item, oldest in res[0].
  typedef struct packed {
    out_t [MaxResults-1:0] res;
    logic [1:0]            n;
  } entry_t;

  localparam logic [7:0] Alphabet [32] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
  };

  function automatic logic [7:0] enc_char(input logic [4:0] sym);
    return Alphabet[sym];
  endfunction

  // Returns {valid, value}; letters match in either case.
  function automatic logic [5:0] dec_symbol(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? (ch - 8'h20) : ch;
    if (up >= 8'h41 && up <= 8'h48) begin
      return {1'b1, 5'(up - 8'h41)};
    end else if (up >= 8'h4A && up <= 8'h4E) begin
      return {1'b1, 5'(up - 8'h4A + 8'd8)};
    end else if (up >= 8'h50 && up <= 8'h5A) begin
      return {1'b1, 5'(up - 8'h50 + 8'd13)};
    end else if (up >= 8'h32 && up <= 8'h39) begin
      return {1'b1, 5'(up - 8'h32 + 8'd24)};
    end
    return 6'd0;
  endfunction

endpackage

### design/b32c_front.sv
// Front end: accepts items, runs the bit accumulator and builds one queue entry
// holding every result the item causes. Depends on b32c_pkg.
module b32c_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                accept,
  input  b32c_pkg::in_t       item,
  output logic                entry_push,
  output b32c_pkg::entry_t    entry
);

  logic       direction;
  logic [6:0] pending_bits;
  logic [2:0] pending_count;
  logic [6:0] pending_bits_next;
  logic [2:0] pending_count_next;

  logic [6:0]  acc_m;
  logic [3:0]  acc_e;
  logic [11:0] a;
  logic [3:0]  c;
  logic [3:0]  rem;
  logic [11:0] rb;
  logic [5:0]  dsym;
  logic [1:0]  n;
  b32c_pkg::out_t [b32c_pkg::MaxResults-1:0] res;

  always_comb begin
    acc_m = pending_bits & 7'((8'd1 << pending_count) - 8'd1);
    acc_e = (pending_count > 3'd4) ? 4'd0 : acc_m[3:0];
    dsym  = b32c_pkg::dec_symbol(item.data_byte);
    res   = '0;
    n     = 2'd0;
    a     = '0;
    c     = '0;
    rem   = '0;
    if (direction == b32c_pkg::DirEncode) begin
      a = {acc_e, item.data_byte};
      c = ((pending_count > 3'd4) ? 4'd0 : {1'b0, pending_count}) + 4'd8;
      res[0] = '{out_byte: b32c_pkg::enc_char(5'(a >> (c - 4'd5))),
                 no_data: 1'b0, last: 1'b0};
      n = 2'd1;
      if (c >= 4'd10) begin
        res[1] = '{out_byte: b32c_pkg::enc_char(5'(a >> (c - 4'd10))),
                   no_data: 1'b0, last: 1'b0};
        n   = 2'd2;
        rem = c - 4'd10;
      end else begin
        rem = c - 4'd5;
      end
    end else if (dsym[5]) begin
      a = {acc_m, dsym[4:0]};
      c = {1'b0, pending_count} + 4'd5;
      if (c >= 4'd8) begin
        res[0] = '{out_byte: 8'(a >> (c - 4'd8)), no_data: 1'b0, last: 1'b0};
        n   = 2'd1;
        rem = c - 4'd8;
      end else begin
        rem = c;
      end
    end else begin
      a   = {5'd0, acc_m};
      rem = {1'b0, pending_count};
    end

    rb = a & ((12'd1 << rem) - 12'd1);

    // Flush: zero-fill the leftover bits into one final symbol or byte, or mark no data if none are left.
    if (item.end_of_message) begin
      if (rem == 4'd0) begin
        res[n] = '{out_byte: 8'd0, no_data: 1'b1, last: 1'b1};
      end else if (direction == b32c_pkg::DirEncode) begin
        res[n] = '{out_byte: b32c_pkg::enc_char(5'(rb << (4'd5 - rem))),
                   no_data: 1'b0, last: 1'b1};
      end else begin
        res[n] = '{out_byte: 8'(rb << (4'd8 - rem)), no_data: 1'b0, last: 1'b1};
      end
      n = n + 2'd1;
      pending_count_next = 3'd0;
      pending_bits_next  = 7'd0;
    end else begin
      pending_count_next = rem[2:0];
      pending_bits_next  = rb[6:0];
    end
  end

  assign entry_push = accept && (n != 2'd0);
  assign entry      = '{res: res, n: n};

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= b32c_pkg::DirEncode;
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (cfg_we) begin
      direction     <= cfg_wdata;
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (accept) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

### design/b32c_queue.sv
// Short entry queue between front and back ends (DEPTH of 2 or more).
// Depends on b32c_pkg for the entry type.
module b32c_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  b32c_pkg::entry_t wr_entry,
  input  logic             rd_en,
  output logic             full,
  output logic             valid,
  output b32c_pkg::entry_t head
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  b32c_pkg::entry_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/b32c_back.sv
// Back end: walks the results of the head queue entry into the output register.
// Depends on b32c_pkg and the assertion macro header.
`include "base32_stream_codec_macros.svh"

module b32c_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  b32c_pkg::entry_t head,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output b32c_pkg::out_t   result
);

  logic           out_valid;
  logic [1:0]     idx;
  logic           take;
  logic           at_end;

  assign take   = q_valid && (!out_valid || pop);
  assign at_end = (idx == head.n - 2'd1);
  assign q_pop  = take && at_end;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (take) begin
      result <= head.res[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `B32C_ASSERT_IMP(a_idx_in_entry, q_valid, idx < head.n, "result index past entry end")
  `B32C_ASSERT_IMP(a_pop_on_take, q_pop, take, "queue popped without a transaction")
  `B32C_ASSERT_IMP(a_last_closes, out_valid && result.last, idx == 2'd0,
                   "last result left entry unfinished")
  `B32C_ASSERT_NXT(a_no_phantom, !q_valid && !out_valid, !out_valid,
                   "result appeared with nothing queued")

endmodule

### design/base32_stream_codec.sv
// Unpadded base32 stream codec. An item's results are written into the queue by the edge that
// takes the item, then loaded one by one into the output register when it is empty or popped.
// Items are taken one per cycle while the queue has room; results leave one per cycle while pop
// is held and more are queued, so encoding (up to two characters per byte) can fill the queue.
// Reset (rst, synchronous): direction set to encode, accumulator, queue and output
// cleared. Depends on b32c_pkg, b32c_front, b32c_queue, b32c_back.
module base32_stream_codec #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             push,
  output logic             full,
  input  b32c_pkg::in_t    item,
  output logic             empty,
  input  logic             pop,
  output b32c_pkg::out_t   result
);

  logic             accept;
  logic             entry_push;
  b32c_pkg::entry_t entry;
  logic             q_valid;
  logic             q_pop;
  b32c_pkg::entry_t head;

  assign accept = push && !full;

  b32c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .item       (item),
    .entry_push (entry_push),
    .entry      (entry)
  );

  b32c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_push),
    .wr_entry (entry),
    .rd_en    (q_pop),
    .full     (full),
    .valid    (q_valid),
    .head     (head)
  );

  b32c_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
